// File: hdl/gradient_color_ramp_defines.svh
// ----------------------------------------------------------------------------
// gradient_color_ramp_defines.svh
// Assertion macros shared by the color ramp RTL. Each macro expects i_clk
// and i_rst_n in scope and checks only while reset is released.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_COLOR_RAMP_DEFINES_SVH
`define GRADIENT_COLOR_RAMP_DEFINES_SVH

// same-cycle implication
`define GRC_CHK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grc check failed");

// next-cycle implication
`define GRC_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grc check failed");

`endif

// File: hdl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Types and constants of the gradient color ramp: word formats, stop entry
// layout, interpolation request and operation codes.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int MAX_STOPS = 8;
    localparam int IDX_W     = $clog2(MAX_STOPS);
    localparam int CNT_W     = $clog2(MAX_STOPS + 1);

    localparam int POS_W     = 17;
    localparam int CH_W      = 8;
    localparam int NCH       = 4;
    localparam int CH_IDX_W  = $clog2(NCH);
    localparam int COL_W     = CH_W * NCH;
    // numerator stays below 256 * span
    localparam int NUM_W     = POS_W + CH_W;
    localparam int MUL_STEPS = 2 * NCH;
    localparam int STEP_W    = $clog2(MUL_STEPS + 1);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [POS_W-1:0] stop_position;
        logic [CH_W-1:0]  stop_red;
        logic [CH_W-1:0]  stop_green;
        logic [CH_W-1:0]  stop_blue;
        logic [CH_W-1:0]  stop_alpha;
        logic [POS_W-1:0] ratio;
    } t_in_word;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
        logic            status;
    } t_out_word;

    // one table entry; red in the low byte of col, alpha in the high byte
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [COL_W-1:0] col;
    } t_stop;

    typedef struct packed {
        logic [COL_W-1:0] c0;
        logic [COL_W-1:0] c1;
        logic [POS_W-1:0] r;
        logic [POS_W-1:0] s;
    } t_lerp_req;

endpackage

// File: hdl/grc_ram.sv
// ----------------------------------------------------------------------------
// grc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/grc_lerp.sv
// ----------------------------------------------------------------------------
// grc_lerp
// Rounded linear interpolation of four channels between two stops.
// One shared 8x17 multiplier builds the four numerators,
// then four restoring dividers produce one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_lerp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  grc_pkg::t_lerp_req         i_req,
    output logic                       o_done,
    output logic [grc_pkg::COL_W-1:0]  o_color
);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_MUL  = 3'b010,
        L_DIV  = 3'b100
    } t_lstate;

    t_lstate                         r_state;
    logic [grc_pkg::STEP_W-1:0]      r_step;
    grc_pkg::t_lerp_req              r_req;
    logic [grc_pkg::POS_W-1:0]       r_sr;
    logic [grc_pkg::NUM_W-1:0]       r_prod;
    logic [grc_pkg::CH_IDX_W-1:0]    r_prod_ch;
    logic [grc_pkg::NUM_W-1:0]       r_num [grc_pkg::NCH];
    logic [grc_pkg::NUM_W-2:0]       r_den;
    logic [grc_pkg::CH_W-1:0]        r_q [grc_pkg::NCH];
    logic                            r_done;

    logic [grc_pkg::CH_IDX_W-1:0]    w_ch;
    logic                            w_term;
    logic [grc_pkg::CH_W-1:0]        w_a;
    logic [grc_pkg::POS_W-1:0]       w_b;
    logic [grc_pkg::NUM_W-1:0]       w_prod;
    logic [grc_pkg::NCH-1:0]         w_ge;

    // multiplier operand select: even step c0*(s-r), odd step c1*r
    assign w_ch   = r_step[grc_pkg::CH_IDX_W:1];
    assign w_term = r_step[0];
    assign w_a    = w_term ? r_req.c1[w_ch*grc_pkg::CH_W +: grc_pkg::CH_W]
                           : r_req.c0[w_ch*grc_pkg::CH_W +: grc_pkg::CH_W];
    assign w_b    = w_term ? r_req.r : r_sr;
    assign w_prod = w_a * w_b;

    // divider compare, one per channel
    always_comb begin
        for (int ch = 0; ch < grc_pkg::NCH; ch++) begin
            w_ge[ch] = (r_num[ch] >= {1'b0, r_den});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_req  <= i_req;
                        r_sr   <= i_req.s - i_req.r;
                        r_step <= '0;
                        // rounding term s/2 seeds every numerator
                        for (int ch = 0; ch < grc_pkg::NCH; ch++) begin
                            r_num[ch] <= grc_pkg::NUM_W'(i_req.s >> 1);
                        end
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    if (r_step != grc_pkg::STEP_W'(grc_pkg::MUL_STEPS)) begin
                        r_prod    <= w_prod;
                        r_prod_ch <= w_ch;
                    end
                    if (r_step != '0) begin
                        r_num[r_prod_ch] <= r_num[r_prod_ch] + r_prod;
                    end
                    if (r_step == grc_pkg::STEP_W'(grc_pkg::MUL_STEPS)) begin
                        r_step  <= '0;
                        r_den   <= {r_req.s, (grc_pkg::CH_W-1)'(0)};
                        r_state <= L_DIV;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                L_DIV: begin
                    for (int ch = 0; ch < grc_pkg::NCH; ch++) begin
                        if (w_ge[ch]) begin
                            r_num[ch] <= r_num[ch] - {1'b0, r_den};
                        end
                        r_q[ch] <= {r_q[ch][grc_pkg::CH_W-2:0], w_ge[ch]};
                    end
                    r_den <= r_den >> 1;
                    if (r_step == grc_pkg::STEP_W'(grc_pkg::CH_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    always_comb begin
        for (int ch = 0; ch < grc_pkg::NCH; ch++) begin
            o_color[ch*grc_pkg::CH_W +: grc_pkg::CH_W] = r_q[ch];
        end
    end

    assign o_done = r_done;

endmodule

// File: hdl/gradient_color_ramp.sv
// Clear, unused code, full add and empty-table evaluate go straight to the
//   output stage; add shifts larger stops up first; evaluate scans the stops
//   and, when it blends, runs multiply, drain, divide and hand-off. Throughput:
//   one word in flight, the next is taken the cycle after the result registers;
//   scan and divider set the pace.
// Reset: synchronous, active low; empties the table (stop memory left as is).
// ----------------------------------------------------------------------------
// gradient_color_ramp
// Sorted color stop table in one RAM with insert, clear and evaluate; the
// evaluate path scans the table and interpolates between neighbor stops.
// ----------------------------------------------------------------------------
`include "gradient_color_ramp_defines.svh"

module gradient_color_ramp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  grc_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output grc_pkg::t_out_word  o_out_word
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INS  = 5'b00010,
        S_SRCH = 5'b00100,
        S_LERP = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                          r_state,      n_state;
    logic [grc_pkg::CNT_W-1:0]       r_cnt,        n_cnt;
    logic [grc_pkg::CNT_W-1:0]       r_k,          n_k;
    logic [grc_pkg::CNT_W-1:0]       r_i,          n_i;
    logic [grc_pkg::CNT_W-1:0]       r_j,          n_j;
    logic                            r_pend,       n_pend;
    grc_pkg::t_stop                  r_new,        n_new;
    grc_pkg::t_stop                  r_prev,       n_prev;
    logic [grc_pkg::POS_W-1:0]       r_ratio,      n_ratio;
    logic [grc_pkg::COL_W-1:0]       r_res_col,    n_res_col;
    logic                            r_res_status, n_res_status;
    logic                            r_out_valid,  n_out_valid;
    grc_pkg::t_out_word              r_out,        n_out;

    logic                            w_in_acc;
    logic                            w_full_add;
    logic                            w_we;
    logic [grc_pkg::IDX_W-1:0]       w_waddr;
    grc_pkg::t_stop                  w_wdata;
    logic [grc_pkg::IDX_W-1:0]       w_raddr;
    grc_pkg::t_stop                  w_rd;
    logic                            w_lerp_start;
    grc_pkg::t_lerp_req              w_lerp_req;
    logic                            w_lerp_done;
    logic [grc_pkg::COL_W-1:0]       w_lerp_color;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    grc_ram #(
        .WIDTH ($bits(grc_pkg::t_stop)),
        .DEPTH (grc_pkg::MAX_STOPS)
    ) u_stop_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    grc_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lerp_start),
        .i_req   (w_lerp_req),
        .o_done  (w_lerp_done),
        .o_color (w_lerp_color)
    );

    // span operands from the previous and current scanned stops
    assign w_lerp_req.c0 = r_prev.col;
    assign w_lerp_req.c1 = w_rd.col;
    assign w_lerp_req.r  = r_ratio - r_prev.pos;
    assign w_lerp_req.s  = w_rd.pos - r_prev.pos;

    // control: accept, insert shift, scan, interpolate, hand off
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_k          = r_k;
        n_i          = r_i;
        n_j          = r_j;
        n_pend       = r_pend;
        n_new        = r_new;
        n_prev       = r_prev;
        n_ratio      = r_ratio;
        n_res_col    = r_res_col;
        n_res_status = r_res_status;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        w_we         = 1'b0;
        w_waddr      = r_k[grc_pkg::IDX_W-1:0];
        w_wdata      = r_new;
        w_raddr      = '0;
        w_lerp_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_res_col    = '0;
                    n_res_status = 1'b0;
                    n_pend       = 1'b0;
                    n_state      = S_DONE;
                    unique case (i_in_word.operation)
                        grc_pkg::OP_ADD: begin
                            n_new.pos = i_in_word.stop_position;
                            n_new.col = {i_in_word.stop_alpha, i_in_word.stop_blue,
                                         i_in_word.stop_green, i_in_word.stop_red};
                            if (r_cnt >= grc_pkg::CNT_W'(grc_pkg::MAX_STOPS)) begin
                                n_res_status = 1'b1;
                            end else begin
                                n_k     = r_cnt;
                                n_state = S_INS;
                            end
                        end
                        grc_pkg::OP_CLEAR: begin
                            n_cnt = '0;
                        end
                        grc_pkg::OP_EVAL: begin
                            n_ratio = i_in_word.ratio;
                            n_i     = '0;
                            if (r_cnt != '0) begin
                                n_state = S_SRCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // walk down from the top, moving larger stops up one slot
            S_INS: begin
                if (!r_pend) begin
                    if (r_k == '0) begin
                        w_we    = 1'b1;
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_DONE;
                    end else begin
                        w_raddr = grc_pkg::IDX_W'(r_k - 1'b1);
                        n_pend  = 1'b1;
                    end
                end else if (w_rd.pos > r_new.pos) begin
                    w_we    = 1'b1;
                    w_wdata = w_rd;
                    n_k     = r_k - 1'b1;
                    if (r_k != grc_pkg::CNT_W'(1)) begin
                        w_raddr = grc_pkg::IDX_W'(r_k - grc_pkg::CNT_W'(2));
                    end else begin
                        n_pend = 1'b0;
                    end
                end else begin
                    w_we    = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_DONE;
                end
            end

            // one read per cycle; compare the word returned for index r_j
            S_SRCH: begin
                if (r_i < r_cnt) begin
                    w_raddr = r_i[grc_pkg::IDX_W-1:0];
                    n_i     = r_i + 1'b1;
                    n_j     = r_i;
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (w_rd.pos >= r_ratio) begin
                        if (r_j == '0 || w_rd.pos == r_prev.pos) begin
                            n_res_col = w_rd.col;
                            n_state   = S_DONE;
                        end else begin
                            w_lerp_start = 1'b1;
                            n_state      = S_LERP;
                        end
                    end else begin
                        n_prev = w_rd;
                        if (r_j == r_cnt - 1'b1) begin
                            n_res_col = (r_cnt >= grc_pkg::CNT_W'(2)) ? w_rd.col : '0;
                            n_state   = S_DONE;
                        end
                    end
                end
            end

            S_LERP: begin
                if (w_lerp_done) begin
                    n_res_col = w_lerp_color;
                    n_state   = S_DONE;
                end
            end

            // load the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.out_red   = r_res_col[0*grc_pkg::CH_W +: grc_pkg::CH_W];
                    n_out.out_green = r_res_col[1*grc_pkg::CH_W +: grc_pkg::CH_W];
                    n_out.out_blue  = r_res_col[2*grc_pkg::CH_W +: grc_pkg::CH_W];
                    n_out.out_alpha = r_res_col[3*grc_pkg::CH_W +: grc_pkg::CH_W];
                    n_out.status    = r_res_status;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_k          <= n_k;
        r_i          <= n_i;
        r_j          <= n_j;
        r_new        <= n_new;
        r_prev       <= n_prev;
        r_ratio      <= n_ratio;
        r_res_col    <= n_res_col;
        r_res_status <= n_res_status;
        r_out        <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // add accepted while the table is full
    assign w_full_add = w_in_acc && (i_in_word.operation == grc_pkg::OP_ADD)
                        && (r_cnt == grc_pkg::CNT_W'(grc_pkg::MAX_STOPS));

    // checks
    `GRC_CHK_IMPL(a_cnt_bound, 1'b1, r_cnt <= grc_pkg::CNT_W'(grc_pkg::MAX_STOPS))
    `GRC_CHK_NEXT(a_full_add_keeps_cnt, w_full_add, r_cnt == $past(r_cnt))
    `GRC_CHK_IMPL(a_lerp_done_in_lerp, w_lerp_done, r_state == S_LERP)
    `GRC_CHK_IMPL(a_out_from_done, $rose(r_out_valid), $past(r_state) == S_DONE)

endmodule
